[rtl/ffha_pkg.sv]
// ffha_pkg: shared types and constants of the first-fit heap allocator
// field widths, operation and status codes, request and result structs
// no dependencies
package ffha_pkg;

  // fixed field widths
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 14;
  localparam int REQ_BYTES_W = 14;
  localparam int OFF_W       = 13;
  localparam int MAXF_W      = 14;
  // width of a byte count turned into words
  localparam int QW          = 13;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_QUERY = 2'd2
  } func_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  // request after byte to word conversion
  typedef struct packed {
    func_t             func;
    logic [QW-1:0]     req_words;
    logic [QW-1:0]     off_words;
    logic [OFF_W-1:0]  off_bytes;
  } req_t;

  // one result
  typedef struct packed {
    status_t           status;
    logic [OFF_W-1:0]  payload_offset;
    logic [MAXF_W-1:0] max_free_bytes;
  } res_t;

endpackage

[rtl/ffha_mem.sv]
// ffha_mem: chunk header store, one write and one registered read per cycle
// generic, no dependencies
module ffha_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 12,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ffha_seq.sv]
// ffha_seq: sequencer that walks the implicit chunk list one header at a time
// merges free neighbors, tracks largest payload and first fit, splits, frees
// depends on ffha_pkg and ffha_mem
module ffha_seq #(
  parameter int POOL_WORDS   = 1024,
  parameter int WORD_BYTES   = 8,
  parameter int HEADER_WORDS = 1,
  parameter int RESET_WORDS  = 1024,
  localparam int SW          = $clog2(POOL_WORDS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [SW-1:0]   cfg_words,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffha_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_ready,
  output ffha_pkg::res_t  res
);
  import ffha_pkg::*;

  localparam int AW = $clog2(POOL_WORDS);
  localparam int DW = SW + 1;
  localparam int MW = (QW > SW) ? QW : SW;
  localparam int PW = (SW + 4 > MAXF_W + 1) ? SW + 4 : MAXF_W + 1;
  localparam int CW = QW + 4;

  typedef enum logic [9:0] {
    S_INIT = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_FCHK = 10'b00_0000_0100,
    S_RD   = 10'b00_0000_1000,
    S_HD   = 10'b00_0001_0000,
    S_MRD  = 10'b00_0010_0000,
    S_MHD  = 10'b00_0100_0000,
    S_SPL1 = 10'b00_1000_0000,
    S_SPL2 = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [SW-1:0] end_word_r, end_word_nxt;
  req_t          req_r, req_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] nxt_r, nxt_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic          found_r, found_nxt;
  logic [SW-1:0] fpos_r, fpos_nxt;
  logic [SW-1:0] fsize_r, fsize_nxt;
  logic [MW-1:0] target_r, target_nxt;
  res_t          res_r, res_nxt;

  // header store
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic          rd_used;
  logic [SW-1:0] rd_size;

  ffha_mem #(.DEPTH(POOL_WORDS), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_used = mem_rdata[SW];
  assign rd_size = mem_rdata[SW-1:0];

  // shared pointer adder
  logic [SW-1:0] add_a, add_b, add_sum;
  assign add_sum = add_a + add_b;

  // derived values
  logic          is_free, walk_cont, fin;
  logic [SW-1:0] boot_words, take, rest, pay;
  logic [MW-1:0] need_ext;
  logic          usable, fits;
  logic [CW-1:0] chk_prod;
  logic [PW-1:0] best_mul, off_mul;

  assign is_free   = (req_r.func == FN_FREE);
  assign walk_cont = (pos_r < end_word_r) && (!is_free || MW'(pos_r) <= target_r);
  assign boot_words = cfg_we ? cfg_words : end_word_r;
  assign need_ext  = MW'(req_r.req_words) + MW'(HEADER_WORDS);
  assign take      = SW'(need_ext);
  assign rest      = fsize_r - take;
  assign usable    = acc_r > SW'(HEADER_WORDS);
  assign pay       = acc_r - SW'(HEADER_WORDS);
  assign fits      = MW'(acc_r) >= need_ext;
  assign chk_prod  = CW'(req_r.off_words) * CW'(WORD_BYTES);
  assign best_mul  = PW'(best_r) * PW'(WORD_BYTES);
  assign off_mul   = (PW'(fpos_r) + PW'(HEADER_WORDS)) * PW'(WORD_BYTES);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    end_word_nxt = end_word_r;
    req_nxt      = req_r;
    pos_nxt      = pos_r;
    nxt_nxt      = nxt_r;
    acc_nxt      = acc_r;
    best_nxt     = best_r;
    found_nxt    = found_r;
    fpos_nxt     = fpos_r;
    fsize_nxt    = fsize_r;
    target_nxt   = target_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = pos_r[AW-1:0];
    mem_wdata    = {1'b0, acc_r};
    mem_re       = 1'b0;
    mem_raddr    = pos_r[AW-1:0];
    add_a        = pos_r;
    add_b        = rd_size;
    fin          = 1'b0;

    unique case (state_r)
      // pool becomes one free chunk at word one
      S_INIT: begin
        if (boot_words >= SW'(2)) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(1);
          mem_wdata = {1'b0, boot_words - SW'(1)};
        end
        end_word_nxt = boot_words;
        state_nxt    = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_we) begin
          if (cfg_words >= SW'(2)) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(1);
            mem_wdata = {1'b0, cfg_words - SW'(1)};
          end
          end_word_nxt = cfg_words;
        end
        if (in_valid) begin
          req_nxt   = req;
          pos_nxt   = SW'(1);
          best_nxt  = '0;
          found_nxt = 1'b0;
          res_nxt   = '{status: ST_OK, payload_offset: '0, max_free_bytes: '0};
          unique case (req.func)
            FN_ALLOC, FN_QUERY: state_nxt = S_RD;
            FN_FREE:            state_nxt = S_FCHK;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      // free offset must be word aligned and past the first header
      S_FCHK: begin
        if (chk_prod == CW'(req_r.off_bytes) &&
            req_r.off_words >= QW'(HEADER_WORDS + 1)) begin
          target_nxt = MW'(req_r.off_words) - MW'(HEADER_WORDS);
          state_nxt  = S_RD;
        end else begin
          res_nxt.status = ST_BADFREE;
          state_nxt      = S_DONE;
        end
      end
      // fetch the header at the walk pointer, or close the walk
      S_RD: begin
        if (walk_cont) begin
          mem_re    = 1'b1;
          state_nxt = S_HD;
        end else begin
          state_nxt = S_DONE;
          unique case (req_r.func)
            FN_FREE:  res_nxt.status = ST_BADFREE;
            FN_QUERY: res_nxt.max_free_bytes = best_mul[MAXF_W-1:0];
            FN_ALLOC: begin
              if (found_r) begin
                state_nxt = S_SPL1;
              end else begin
                res_nxt.status = ST_NOSPACE;
              end
            end
            default: res_nxt.status = ST_OK;
          endcase
        end
      end
      S_HD: begin
        if (is_free) begin
          if (MW'(pos_r) == target_r) begin
            if (rd_used) begin
              mem_we         = 1'b1;
              mem_wdata      = {1'b0, rd_size};
              res_nxt.status = ST_OK;
            end else begin
              res_nxt.status = ST_BADFREE;
            end
            state_nxt = S_DONE;
          end else begin
            pos_nxt   = add_sum;
            state_nxt = S_RD;
          end
        end else if (rd_used) begin
          pos_nxt   = add_sum;
          state_nxt = S_RD;
        end else begin
          acc_nxt   = rd_size;
          nxt_nxt   = add_sum;
          state_nxt = S_MRD;
        end
      end
      // look at the next neighbor of a free chunk
      S_MRD: begin
        if (nxt_r < end_word_r) begin
          mem_re    = 1'b1;
          mem_raddr = nxt_r[AW-1:0];
          state_nxt = S_MHD;
        end else begin
          fin = 1'b1;
        end
      end
      S_MHD: begin
        if (!rd_used) begin
          add_a     = nxt_r;
          nxt_nxt   = add_sum;
          acc_nxt   = acc_r + rd_size;
          state_nxt = S_MRD;
        end else begin
          fin = 1'b1;
        end
      end
      // mark the chosen chunk used, cut it if something is left over
      S_SPL1: begin
        add_a     = fpos_r;
        add_b     = take;
        mem_we    = 1'b1;
        mem_waddr = fpos_r[AW-1:0];
        mem_wdata = {1'b1, (rest != '0) ? take : fsize_r};
        if (rest != '0) begin
          nxt_nxt   = add_sum;
          acc_nxt   = rest;
          state_nxt = S_SPL2;
        end else begin
          res_nxt.status         = ST_OK;
          res_nxt.payload_offset = off_mul[OFF_W-1:0];
          state_nxt              = S_DONE;
        end
      end
      S_SPL2: begin
        mem_we                 = 1'b1;
        mem_waddr              = nxt_r[AW-1:0];
        mem_wdata              = {1'b0, acc_r};
        res_nxt.status         = ST_OK;
        res_nxt.payload_offset = off_mul[OFF_W-1:0];
        state_nxt              = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase

    // close a merged free chunk: write its size, score it, move on
    if (fin) begin
      mem_we = 1'b1;
      if (usable && pay > best_r) begin
        best_nxt = pay;
      end
      if (!found_r && req_r.func == FN_ALLOC && fits) begin
        found_nxt = 1'b1;
        fpos_nxt  = pos_r;
        fsize_nxt = acc_r;
      end
      pos_nxt   = nxt_r;
      state_nxt = S_RD;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      end_word_r <= SW'(RESET_WORDS);
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      end_word_r <= end_word_nxt;
      found_r    <= found_nxt;
    end
  end

  // walk datapath registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    pos_r    <= pos_nxt;
    nxt_r    <= nxt_nxt;
    acc_r    <= acc_nxt;
    best_r   <= best_nxt;
    fpos_r   <= fpos_nxt;
    fsize_r  <= fsize_nxt;
    target_r <= target_nxt;
    res_r    <= res_nxt;
  end

  // a request closes the input until its result has been handed over
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a request was taken");

  // walk writes stay inside the pool
  a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && state_r != S_INIT && state_r != S_IDLE |-> SW'(mem_waddr) < end_word_r)
    else $error("header write outside the pool");

  // every header reached by the walk holds a nonzero size
  a_header_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HD || state_r == S_MHD |-> rd_size != '0)
    else $error("chunk header of size zero on the walk");

  // the walk pointer never passes the pool end
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> pos_r <= end_word_r)
    else $error("walk pointer beyond pool end");

endmodule

[rtl/first_fit_heap_allocator.sv]
// first_fit_heap_allocator: top level, byte to word conversion, config, result register
// depends on ffha_pkg and ffha_seq
//
// First-fit heap allocator over a word-aligned pool kept as an implicit chunk list,
// one header of size and used flag per chunk start, word zero reserved. Each request
// gives one result, and one request is at work at a time. Timing is set by the
// header memory, with one write and one registered read port, walked by the
// sequencer. Allocate and query walk every chunk: they read each chunk header, merge
// each free neighbor and close each run of free chunks, then finish, split and hand
// the result over. Free walks only up to the chunk it releases. Writing pool_bytes
// rebuilds the pool as one free chunk in the same cycle, but only while no request
// is at work, and after reset the block sets up the pool in its init state before it
// accepts a request.
module first_fit_heap_allocator #(
  parameter int POOL_WORDS   = 1024,
  parameter int WORD_BYTES   = 8,
  parameter int HEADER_WORDS = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ffha_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ffha_pkg::FUNC_W-1:0]      in_func,
  input  logic [ffha_pkg::REQ_BYTES_W-1:0] in_request_bytes,
  input  logic [ffha_pkg::OFF_W-1:0]       in_free_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ffha_pkg::STATUS_W-1:0]    out_status,
  output logic [ffha_pkg::OFF_W-1:0]       out_payload_offset,
  output logic [ffha_pkg::MAXF_W-1:0]      out_max_free_bytes
);
  import ffha_pkg::*;

  localparam int SW          = $clog2(POOL_WORDS + 1);
  localparam int MW          = (QW > SW) ? QW : SW;
  localparam int RESET_WORDS = ((8192 / WORD_BYTES) > POOL_WORDS) ?
                               POOL_WORDS : (8192 / WORD_BYTES);
  // reciprocal divide, exact for 15-bit numerators and word sizes up to 8
  localparam int DIV_SHIFT   = 18;
  localparam int RECIP       = (2 ** DIV_SHIFT + WORD_BYTES - 1) / WORD_BYTES;
  localparam int NUM_W       = REQ_BYTES_W + 1;
  localparam int PROD_W      = 32;

  // pool size in words, capped at the memory depth
  logic [PROD_W-1:0] cfg_prod;
  logic [QW-1:0]     cfg_q;
  logic [SW-1:0]     cfg_words;

  assign cfg_prod  = PROD_W'(cfg_wdata) * PROD_W'(RECIP);
  assign cfg_q     = cfg_prod[DIV_SHIFT +: QW];
  assign cfg_words = (MW'(cfg_q) > MW'(POOL_WORDS)) ? SW'(POOL_WORDS) : SW'(cfg_q);

  // request bytes rounded up to words, at least one word
  logic [NUM_W-1:0]  req_num;
  logic [PROD_W-1:0] req_prod;
  logic [QW-1:0]     req_q;
  logic [PROD_W-1:0] off_prod;
  req_t              req;

  assign req_num  = NUM_W'(in_request_bytes) + NUM_W'(WORD_BYTES - 1);
  assign req_prod = PROD_W'(req_num) * PROD_W'(RECIP);
  assign req_q    = req_prod[DIV_SHIFT +: QW];
  assign off_prod = PROD_W'(in_free_offset) * PROD_W'(RECIP);

  assign req.func      = func_t'(in_func);
  assign req.req_words = (req_q == '0) ? QW'(1) : req_q;
  assign req.off_words = off_prod[DIV_SHIFT +: QW];
  assign req.off_bytes = in_free_offset;

  // list walker
  logic res_valid, res_ready;
  res_t res;

  ffha_seq #(
    .POOL_WORDS   (POOL_WORDS),
    .WORD_BYTES   (WORD_BYTES),
    .HEADER_WORDS (HEADER_WORDS),
    .RESET_WORDS  (RESET_WORDS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_words (cfg_words),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register, refilled as soon as the previous result is taken
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_payload_offset = out_res_r.payload_offset;
  assign out_max_free_bytes = out_res_r.max_free_bytes;

endmodule
